// ----- rtl/bmcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-click detector package
// Shared types, register codes, widths and the per-count wait limit table.
// ----------------------------------------------------------------------------
package bmcd_pkg;

  // Width of the two saturating tick counters (valid from 12 to 32).
  localparam int TIME_BITS = 16;
  // Width used when a tick counter is compared against a 16-bit register.
  localparam int CMP_W     = (TIME_BITS > 16) ? TIME_BITS : 16;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [2:0]           event_t;
  typedef logic [3:0]           count_t;
  typedef logic [10:0]          limit_t;

  localparam event_t EV_NONE = 3'd0;
  localparam event_t EV_LONG = 3'd7;

  localparam count_t COUNT_MAX   = 4'd15;
  localparam count_t CLICKS_MAX  = 4'd6;
  localparam count_t LEVEL_COUNT = 4'd2;

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LONG_PRESS = 3'd1,
    REG_POLL       = 3'd2,
    REG_WINDOW     = 3'd3,
    REG_REQ_HIGH   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [7:0]  poll_period;
    logic [7:0]  check_window;
    logic [7:0]  required_high;
  } cfg_t;

  // Ticks a given click count must wait before it may be confirmed.
  function automatic limit_t wait_limit(input count_t cnt);
    limit_t lim;
    case (cnt) inside
      4'd1, 4'd2: lim = 11'd400;
      4'd3:       lim = 11'd600;
      4'd4:       lim = 11'd800;
      4'd5:       lim = 11'd1200;
      4'd6:       lim = 11'd1400;
      default:    lim = 11'd0;
    endcase
    return lim;
  endfunction

endpackage

// ----- rtl/button_multi_click_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-click detector core
// Turns one button sample per tick into click-count and long-press events.
// ----------------------------------------------------------------------------
// Usage: each input beat on in_level is one millisecond sample of the button
// pin (1 released, 0 pressed). Every accepted beat yields exactly one result
// beat on out_event_res: 0 for no event, 1 to 6 for that many clicks, 7 for a
// long press. Results leave in the order the samples arrived.
// Each result is registered: a sample accepted at one edge shows its result on
// the output from the next cycle. Throughput is one beat per cycle while
// out_ready is high; the whole tick update is a single pass of counter and
// compare logic ahead of the result register.
// in_ready is high whenever the result register is empty or is being emptied
// in the same cycle, so a stalled receiver holds the result and stops input
// after one beat, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) restores the default timings, marks the
// button released, saturates both tick counters, clears the press count and
// starts in polling mode with an empty result register.
// The APB-style port writes the five settings at byte addresses 0, 4, 8, 12,
// 16 (paddr[1:0] unused); others are ignored. Change them only while idle.
// ----------------------------------------------------------------------------
module button_multi_click_detector_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_event_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmcd_pkg::APB_AW-1:0] paddr,
  input  logic [bmcd_pkg::APB_DW-1:0] pwdata,
  output logic [bmcd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bmcd_pkg::*;

  cfg_t   cfg;
  event_t ev;
  logic   accept;
  logic   can_load;

  // A sample is taken only when the result register can take its event.
  assign in_ready = can_load;
  assign accept   = in_valid & can_load;

  bmcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmcd_tick u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (accept),
    .level   (in_level),
    .cfg     (cfg),
    .ev      (ev)
  );

  bmcd_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (accept),
    .ev            (ev),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res)
  );

endmodule

// ----- rtl/bmcd_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-click detector configuration registers
// APB-style register file holding the five timing and threshold settings.
// ----------------------------------------------------------------------------
module bmcd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bmcd_pkg::APB_AW-1:0] paddr,
  input  logic [bmcd_pkg::APB_DW-1:0] pwdata,
  output logic [bmcd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output bmcd_pkg::cfg_t             cfg
);
  import bmcd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:   cfg_nxt.debounce_ticks   = pwdata[15:0];
        REG_LONG_PRESS: cfg_nxt.long_press_ticks = pwdata[15:0];
        REG_POLL:       cfg_nxt.poll_period      = pwdata[7:0];
        REG_WINDOW:     cfg_nxt.check_window     = pwdata[7:0];
        REG_REQ_HIGH:   cfg_nxt.required_high    = pwdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE:   prdata = APB_DW'(cfg_r.debounce_ticks);
      REG_LONG_PRESS: prdata = APB_DW'(cfg_r.long_press_ticks);
      REG_POLL:       prdata = APB_DW'(cfg_r.poll_period);
      REG_WINDOW:     prdata = APB_DW'(cfg_r.check_window);
      REG_REQ_HIGH:   prdata = APB_DW'(cfg_r.required_high);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= 16'd200;
      cfg_r.long_press_ticks <= 16'd4000;
      cfg_r.poll_period      <= 8'd100;
      cfg_r.check_window     <= 8'd200;
      cfg_r.required_high    <= 8'd199;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/bmcd_tick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-click detector tick logic
// Holds the detector state and advances it by one tick per accepted sample.
// ----------------------------------------------------------------------------
module bmcd_tick (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_en,
  input  logic              level,
  input  bmcd_pkg::cfg_t    cfg,
  output bmcd_pkg::event_t  ev
);
  import bmcd_pkg::*;

  logic   prev_level_r,    prev_level_nxt;
  time_t  since_press_r,   since_press_nxt;
  time_t  since_first_r,   since_first_nxt;
  count_t press_count_r,   press_count_nxt;
  logic [7:0] poll_timer_r,   poll_timer_nxt;
  logic       checking_r,     checking_nxt;
  logic [7:0] window_timer_r, window_timer_nxt;
  logic [7:0] high_samples_r, high_samples_nxt;
  count_t latched_count_r, latched_count_nxt;

  time_t      sp_inc;
  time_t      sf_inc;
  logic [CMP_W-1:0] sp_ext;
  logic       long_hit;
  logic       click_hit;

  always_comb begin
    prev_level_nxt    = level;
    since_press_nxt   = since_press_r;
    since_first_nxt   = since_first_r;
    press_count_nxt   = press_count_r;
    poll_timer_nxt    = poll_timer_r;
    checking_nxt      = checking_r;
    window_timer_nxt  = window_timer_r;
    high_samples_nxt  = high_samples_r;
    latched_count_nxt = latched_count_r;
    ev                = EV_NONE;
    long_hit          = 1'b0;
    click_hit         = 1'b0;

    // Both counters saturate at all ones.
    sp_inc = (&since_press_r) ? since_press_r : since_press_r + 1'b1;
    sf_inc = (&since_first_r) ? since_first_r : since_first_r + 1'b1;
    since_press_nxt = sp_inc;
    since_first_nxt = sf_inc;

    // A falling edge restarts the press timer; the press counts only past debounce.
    if (prev_level_r && !level) begin
      since_press_nxt = '0;
      if (CMP_W'(sf_inc) > CMP_W'(cfg.debounce_ticks)) begin
        since_first_nxt = '0;
        if (press_count_r != COUNT_MAX) begin
          press_count_nxt = press_count_r + 1'b1;
        end
      end
    end

    sp_ext = CMP_W'(since_press_nxt);

    if (checking_r) begin
      if (level && (high_samples_r != 8'hFF)) begin
        high_samples_nxt = high_samples_r + 1'b1;
      end
      if (window_timer_r != 8'hFF) begin
        window_timer_nxt = window_timer_r + 1'b1;
      end
      if (window_timer_nxt >= cfg.check_window) begin
        if (high_samples_nxt >= cfg.required_high) begin
          ev              = event_t'(latched_count_r);
          press_count_nxt = '0;
          since_press_nxt = '1;
        end
        checking_nxt   = 1'b0;
        poll_timer_nxt = '0;
      end
    end else begin
      if (poll_timer_r != 8'hFF) begin
        poll_timer_nxt = poll_timer_r + 1'b1;
      end
      if (poll_timer_nxt >= cfg.poll_period) begin
        poll_timer_nxt = '0;
        long_hit  = (sp_ext > CMP_W'(cfg.long_press_ticks)) && !level &&
                    (press_count_nxt != '0);
        click_hit = (press_count_nxt != '0) && (press_count_nxt <= CLICKS_MAX) &&
                    (sp_ext >= CMP_W'(wait_limit(press_count_nxt))) &&
                    ((press_count_nxt > LEVEL_COUNT) || level);
        if (long_hit) begin
          ev              = EV_LONG;
          press_count_nxt = '0;
          since_press_nxt = '1;
        end else if (click_hit) begin
          checking_nxt      = 1'b1;
          latched_count_nxt = press_count_nxt;
          window_timer_nxt  = '0;
          high_samples_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r    <= 1'b1;
      since_press_r   <= '1;
      since_first_r   <= '1;
      press_count_r   <= '0;
      poll_timer_r    <= '0;
      checking_r      <= 1'b0;
      window_timer_r  <= '0;
      high_samples_r  <= '0;
      latched_count_r <= '0;
    end else if (tick_en) begin
      prev_level_r    <= prev_level_nxt;
      since_press_r   <= since_press_nxt;
      since_first_r   <= since_first_nxt;
      press_count_r   <= press_count_nxt;
      poll_timer_r    <= poll_timer_nxt;
      checking_r      <= checking_nxt;
      window_timer_r  <= window_timer_nxt;
      high_samples_r  <= high_samples_nxt;
      latched_count_r <= latched_count_nxt;
    end
  end

endmodule

// ----- rtl/bmcd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-click detector result register
// Holds one result beat and lets a new one in as the old one leaves.
// ----------------------------------------------------------------------------
module bmcd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  bmcd_pkg::event_t ev,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output bmcd_pkg::event_t out_event_res
);
  import bmcd_pkg::*;

  logic   valid_r, valid_nxt;
  event_t data_r;

  assign can_load      = !valid_r || out_ready;
  assign out_valid     = valid_r;
  assign out_event_res = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= ev;
    end
  end

endmodule
